### sv/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Holds command codes, controller state codes and the fixed field widths.
// No dependencies.
package ple_pkg;

  // Field widths of the request and result items
  localparam int unsigned CmdW     = 3;
  localparam int unsigned PosW     = 6;
  localparam int unsigned ValW     = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned STdataW  = 40;  // position + value, padded to bytes
  localparam int unsigned MTdataW  = 48;  // ok + read_value + found + length

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

### sv/positional_list_engine.sv
// Positional list engine: ordered list of signed 32-bit values in one RAM; uses ple_pkg, ple_ram.
// Clear, rejects, appends and locates on an empty list need no RAM read; get reads one entry;
// insert and delete shift the entries behind the position; locate scans until the first hit.
// One request at a time, one RAM move per cycle; the next is taken once the result loads, and
// a result still held in the output register stalls the engine before that load.
// Reset: length goes to zero at once; the RAM is not cleared (only 1..length is ever read).
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [STdataW-1:0] s_axis_tdata_i,  // position[5:0], value[37:6], zero pad
  input  logic [CmdW-1:0]    s_axis_tuser_i,  // cmd[2:0]
  // Result channel
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [MTdataW-1:0] m_axis_tdata_o   // ok[0], read_value[32:1],
                                              // found_position[38:33],
                                              // length[44:39], zero pad
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ((CW > PosW) ? CW : PosW) + 1;

  // Request fields
  logic [PosW-1:0] in_pos;
  logic [ValW-1:0] in_val;
  cmd_e            in_cmd;
  assign in_pos = s_axis_tdata_i[PosW-1:0];
  assign in_val = s_axis_tdata_i[PosW+ValW-1:PosW];
  assign in_cmd = cmd_e'(s_axis_tuser_i);

  // Control registers
  state_e         state_q, state_d;
  logic           rd_act_q, rd_act_d;
  logic           p_vld_q, p_vld_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           m_valid_q, m_valid_d;

  // Payload registers
  cmd_e            op_q, op_d;
  logic            ok_q, ok_d;
  logic [AW-1:0]   pa_q, pa_d;
  logic [ValW-1:0] val_q, val_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]   rd_end_q, rd_end_d;
  logic            rd_up_q, rd_up_d;
  logic [AW-1:0]   p_addr_q, p_addr_d;
  logic [ValW-1:0] rdv_q, rdv_d;
  logic [LenW-1:0] fnd_q, fnd_d;
  logic            mo_ok_q, mo_ok_d;
  logic [ValW-1:0] mo_rdv_q, mo_rdv_d;
  logic [LenW-1:0] mo_fnd_q, mo_fnd_d;
  logic [LenW-1:0] mo_len_q, mo_len_d;

  // RAM port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ValW-1:0] ram_wdata;
  logic            ram_re;
  logic [ValW-1:0] ram_rdata;

  // Helpers
  logic            acc;
  logic            out_free;
  logic [EW-1:0]   pos_e, cnt_e, pm1_e, cm1_e, hit_e, len_e;

  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign pos_e    = EW'(in_pos);
  assign cnt_e    = EW'(cnt_q);
  assign pm1_e    = pos_e - EW'(1);
  assign cm1_e    = cnt_e - EW'(1);
  assign hit_e    = EW'(p_addr_q) + EW'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Controller
  always_comb begin
    state_d   = state_q;
    rd_act_d  = rd_act_q;
    p_vld_d   = 1'b0;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    op_d      = op_q;
    ok_d      = ok_q;
    pa_d      = pa_q;
    val_d     = val_q;
    rd_ptr_d  = rd_ptr_q;
    rd_end_d  = rd_end_q;
    rd_up_d   = rd_up_q;
    p_addr_d  = rd_ptr_q;
    rdv_d     = rdv_q;
    fnd_d     = fnd_q;
    mo_ok_d   = mo_ok_q;
    mo_rdv_d  = mo_rdv_q;
    mo_fnd_d  = mo_fnd_q;
    mo_len_d  = mo_len_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    len_e     = cnt_e;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d  = ST_RUN;
          op_d     = in_cmd;
          val_d    = in_val;
          pa_d     = pm1_e[AW-1:0];
          rdv_d    = '0;
          fnd_d    = '0;
          ok_d     = 1'b0;
          rd_act_d = 1'b0;
          rd_ptr_d = pm1_e[AW-1:0];
          rd_end_d = cm1_e[AW-1:0];
          rd_up_d  = 1'b1;
          case (in_cmd)
            CMD_INSERT: begin
              ok_d = (pos_e != '0) && (pos_e <= cnt_e + EW'(1)) &&
                     (cnt_e < EW'(CAPACITY));
              // entries from the tail down to the position move back by one
              rd_act_d = ok_d && (pos_e <= cnt_e);
              rd_ptr_d = cm1_e[AW-1:0];
              rd_end_d = pm1_e[AW-1:0];
              rd_up_d  = 1'b0;
            end
            CMD_DELETE: begin
              ok_d     = (pos_e != '0) && (pos_e <= cnt_e);
              rd_act_d = ok_d;
            end
            CMD_GET: begin
              ok_d     = (pos_e != '0) && (pos_e <= cnt_e);
              rd_act_d = ok_d;
              rd_end_d = pm1_e[AW-1:0];
            end
            CMD_LOCATE: begin
              ok_d     = 1'b1;
              rd_act_d = (cnt_q != '0);
              rd_ptr_d = '0;
            end
            CMD_CLEAR: begin
              ok_d = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_RUN: begin
        // issue one read per cycle
        if (rd_act_q) begin
          ram_re  = 1'b1;
          p_vld_d = 1'b1;
          if (rd_ptr_q == rd_end_q) begin
            rd_act_d = 1'b0;
          end else if (rd_up_q) begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end else begin
            rd_ptr_d = rd_ptr_q - AW'(1);
          end
        end
        // handle the entry read in the previous cycle
        if (p_vld_q) begin
          case (op_q)
            CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = p_addr_q + AW'(1);
              ram_wdata = ram_rdata;
            end
            CMD_DELETE: begin
              if (p_addr_q == pa_q) begin
                rdv_d = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = p_addr_q - AW'(1);
                ram_wdata = ram_rdata;
              end
            end
            CMD_GET: begin
              rdv_d = ram_rdata;
            end
            CMD_LOCATE: begin
              if (ram_rdata == val_q) begin
                fnd_d    = hit_e[LenW-1:0];
                rd_act_d = 1'b0;
                p_vld_d  = 1'b0;
              end
            end
            default: begin
              rdv_d = rdv_q;
            end
          endcase
        end
        if (!rd_act_q && !p_vld_q) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        // final write, length update and result load
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          case (op_q)
            CMD_INSERT: begin
              if (ok_q) begin
                ram_we    = 1'b1;
                ram_waddr = pa_q;
                ram_wdata = val_q;
                cnt_d     = cnt_q + CW'(1);
                len_e     = cnt_e + EW'(1);
              end
            end
            CMD_DELETE: begin
              if (ok_q) begin
                cnt_d = cnt_q - CW'(1);
                len_e = cm1_e;
              end
            end
            CMD_CLEAR: begin
              cnt_d = '0;
              len_e = '0;
            end
            default: begin
              len_e = cnt_e;
            end
          endcase
          mo_ok_d  = ok_q;
          mo_rdv_d = rdv_q;
          mo_fnd_d = fnd_q;
          mo_len_d = len_e[LenW-1:0];
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_act_q  <= 1'b0;
      p_vld_q   <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_act_q  <= rd_act_d;
      p_vld_q   <= p_vld_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ok_q     <= ok_d;
    pa_q     <= pa_d;
    val_q    <= val_d;
    rd_ptr_q <= rd_ptr_d;
    rd_end_q <= rd_end_d;
    rd_up_q  <= rd_up_d;
    p_addr_q <= p_addr_d;
    rdv_q    <= rdv_d;
    fnd_q    <= fnd_d;
    mo_ok_q  <= mo_ok_d;
    mo_rdv_q <= mo_rdv_d;
    mo_fnd_q <= mo_fnd_d;
    mo_len_q <= mo_len_d;
  end

  // List storage
  ple_ram #(
    .Width (ValW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Result channel
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {
    {(MTdataW - 1 - ValW - 2*LenW){1'b0}}, mo_len_q, mo_fnd_q, mo_rdv_q, mo_ok_q
  };

endmodule

### sv/ple_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the list storage. No dependencies.
module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### test/ple_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the positional list engine: watches both stream channels,
// keeps its own copy of the list and checks every result in order.
// Depends on ple_pkg.
module ple_result_checker
  import ple_pkg::*;
#(
  parameter int unsigned Capacity = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel, observed only
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  logic [STdataW-1:0] req_data_i,       // position[5:0], value[37:6], zero pad
  input  logic [CmdW-1:0]    req_cmd_i,        // cmd[2:0]
  // Result channel, observed only
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [MTdataW-1:0] res_data_i,       // ok[0], read_value[32:1],
                                               // found_position[38:33],
                                               // length[44:39], zero pad
  // Status for the testbench top
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 full_inserts_o,
  output int                 list_length_o      // predicted length, for shaping stimulus
);

  localparam int MaxReports = 60;

  // Result item, ok in the lowest bit as on the bus
  typedef struct packed {
    logic [LenW-1:0] length;
    logic [PosW-1:0] found_position;
    logic [ValW-1:0] read_value;
    logic            ok;
  } list_result_t;

  // Shadow copy of the list
  logic [ValW-1:0] list_mem [Capacity];
  int              list_len;

  list_result_t    expected_results [$];
  list_result_t    seen_result;
  list_result_t    want_result;
  int              mismatches;
  int              checked;
  int              full_inserts;

  // One line per mismatch; quiet past the cap so a broken block stays readable
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
               $time, checked, what, got, want);
  endtask

  // Applies one request to the shadow list and returns the result it must give
  function automatic list_result_t apply_list_command(input logic [CmdW-1:0] cmd,
                                                      input logic [PosW-1:0] pos,
                                                      input logic [ValW-1:0] val);
    list_result_t res;
    int           p;
    int           k;
    res = '0;
    p   = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (list_len == Capacity) full_inserts++;
        if (p >= 1 && p <= list_len + 1 && list_len < Capacity) begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          res.ok         = 1'b1;
        end
      end
      CMD_LOCATE: begin
        // first match wins
        for (k = 0; k < list_len && res.found_position == '0; k++)
          if (list_mem[k] == val) res.found_position = PosW'(k + 1);
        res.ok = 1'b1;
      end
      CMD_CLEAR: begin
        list_len = 0;
        res.ok   = 1'b1;
      end
      default: ;  // undefined codes are rejected, list untouched
    endcase
    res.length = LenW'(list_len);
    return res;
  endfunction

  // Results are matched before requests: a request taken at this edge
  // cannot already have its result on the bus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len     = 0;
      mismatches   = 0;
      checked      = 0;
      full_inserts = 0;
      expected_results.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      full_inserts_o <= 0;
      list_length_o  <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        seen_result = list_result_t'(res_data_i[$bits(list_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_data_i[31:0], '0);
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.ok !== want_result.ok)
            report_mismatch("ok", 32'(seen_result.ok), 32'(want_result.ok));
          if (seen_result.read_value !== want_result.read_value)
            report_mismatch("read_value", seen_result.read_value, want_result.read_value);
          if (seen_result.found_position !== want_result.found_position)
            report_mismatch("found_position", 32'(seen_result.found_position),
                            32'(want_result.found_position));
          if (seen_result.length !== want_result.length)
            report_mismatch("length", 32'(seen_result.length), 32'(want_result.length));
        end
        checked++;
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(apply_list_command(req_cmd_i, req_data_i[PosW-1:0],
                                                      req_data_i[PosW+ValW-1:PosW]));
      fail_count_o   <= mismatches;
      pending_o      <= expected_results.size();
      checked_o      <= checked;
      full_inserts_o <= full_inserts;
      list_length_o  <= list_len;
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the positional list engine: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on ple_pkg,
// positional_list_engine and ple_result_checker.
module tb_top;
  import ple_pkg::*;

  localparam int unsigned Capacity    = 32;
  localparam int          IdleLimit   = 3000;
  localparam int          DrainCycles = 2 * Capacity + 16;
  localparam int          PhaseItems  = 276;
  localparam int          NumCodes    = 1 << CmdW;

  // Command codes the block does not define
  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;

  // Values reused often so that locate finds hits and duplicates
  localparam logic [ValW-1:0] ValuePool [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_002A, 32'hDEAD_BEEF
  };

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} burst_mode_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [STdataW-1:0] req_data  = '0;
  logic [CmdW-1:0]    req_cmd   = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [MTdataW-1:0] res_data;

  int fail_count;
  int pending;
  int checked;
  int full_inserts;
  int list_len;

  int send_idle_pct;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;
  int sent_by_cmd [NumCodes];

  positional_list_engine #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_cmd),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  ple_result_checker #(
    .Capacity(Capacity)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_valid_i    (req_valid),
    .req_ready_i    (req_ready),
    .req_data_i     (req_data),
    .req_cmd_i      (req_cmd),
    .res_valid_i    (res_valid),
    .res_ready_i    (res_ready),
    .res_data_i     (res_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_inserts_o (full_inserts),
    .list_length_o  (list_len)
  );

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Result back-pressure
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Cycles with no request and no result taken
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IdleLimit);
    $display("watchdog: no traffic for %0d cycles", IdleLimit);
    $display("FAIL");
    $finish;
  end

  // Presents one request after a random gap and waits until it is taken.
  // Valid stays high when the next request follows without a gap.
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_cmd   <= cmd;
    req_data  <= {{(STdataW-PosW-ValW){1'b0}}, val, pos};
    do @(posedge clk); while (!(req_valid && req_ready));
    sent_by_cmd[cmd]++;
  endtask

  function automatic logic [ValW-1:0] pick_value(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return ValuePool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Bursts that grow, shrink or churn the list with well-formed positions,
  // plus a share of raw noise over every field.
  task automatic run_random(input int n_items);
    burst_mode_e     mode;
    int              burst_left;
    int              len;
    int              roll;
    int              w_ins;
    int              w_del;
    int              w_get;
    int              w_loc;
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    mode       = MODE_MIXED;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        mode       = burst_mode_e'($urandom_range(2));
        burst_left = $urandom_range(60, 20);
      end
      burst_left--;
      len = list_len;
      case (mode)
        MODE_GROW:   begin w_ins = 70; w_del = 5;  w_get = 10; w_loc = 15; end
        MODE_SHRINK: begin w_ins = 15; w_del = 55; w_get = 12; w_loc = 18; end
        default:     begin w_ins = 35; w_del = 25; w_get = 17; w_loc = 20; end
      endcase
      if ($urandom_range(99) < 8) begin
        cmd = CmdW'($urandom_range(NumCodes - 1));
        pos = PosW'($urandom_range(63));
        val = $urandom;
      end else begin
        roll = $urandom_range(99);
        pos  = PosW'($urandom_range(63));
        val  = pick_value(50);
        if (roll < w_ins) begin
          cmd = CMD_INSERT;
          pos = PosW'($urandom_range(len + 1, 1));
        end else if (roll < w_ins + w_del) begin
          cmd = CMD_DELETE;
          pos = (len == 0) ? PosW'(1) : PosW'($urandom_range(len, 1));
        end else if (roll < w_ins + w_del + w_get) begin
          cmd = CMD_GET;
          pos = (len == 0) ? PosW'(1) : PosW'($urandom_range(len, 1));
        end else if (roll < w_ins + w_del + w_get + w_loc) begin
          cmd = CMD_LOCATE;
          val = pick_value(80);
        end else begin
          cmd = CMD_CLEAR;
        end
      end
      send_request(cmd, pos, val);
    end
  endtask

  initial begin
    int code;
    send_idle_pct = 11;
    recv_idle_pct <= 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, bad positions, extremes, every command
    send_request(CMD_GET,    6'd1,  32'h0);
    send_request(CMD_DELETE, 6'd1,  32'h0);
    send_request(CMD_LOCATE, 6'd0,  32'h0);
    send_request(CMD_INSERT, 6'd0,  32'h1111_1111);
    send_request(CMD_INSERT, 6'd2,  32'h2222_2222);
    send_request(CMD_INSERT, 6'd1,  32'h8000_0000);
    send_request(CMD_INSERT, 6'd2,  32'h7FFF_FFFF);
    send_request(CMD_INSERT, 6'd1,  32'hFFFF_FFFF);
    send_request(CMD_INSERT, 6'd2,  32'h0000_0000);
    send_request(CMD_INSERT, 6'd5,  32'h0000_0000);
    send_request(CMD_LOCATE, 6'd63, 32'h7FFF_FFFF);
    send_request(CMD_LOCATE, 6'd0,  32'h0000_0000);
    send_request(CMD_LOCATE, 6'd0,  32'h0001_2345);
    send_request(CMD_GET,    6'd63, 32'h0);
    send_request(CMD_GET,    6'd4,  32'h0);
    send_request(CMD_DELETE, 6'd6,  32'h0);
    send_request(CMD_DELETE, 6'd5,  32'h0);
    send_request(CMD_DELETE, 6'd2,  32'h0);
    for (code = CmdUnusedLo; code <= CmdUnusedHi; code++)
      send_request(CmdUnusedLo + CmdW'(code - CmdUnusedLo), 6'd1, 32'hFFFF_FFFF);
    send_request(CMD_CLEAR,  6'd0,  32'h0);
    send_request(CMD_GET,    6'd1,  32'h0);

    // Random: slow receiver, slow sender, then no idling at all
    run_random(PhaseItems);
    send_idle_pct = 50;
    recv_idle_pct <= 11;
    run_random(PhaseItems);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(PhaseItems);
    req_valid <= 1'b0;

    // Drain, then allow time for any stray result
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("requests: %0d insert, %0d delete, %0d get, %0d locate, %0d clear, %0d undefined",
             sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_DELETE], sent_by_cmd[CMD_GET],
             sent_by_cmd[CMD_LOCATE], sent_by_cmd[CMD_CLEAR],
             sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7]);
    $display("%0d results checked, %0d inserts against a full list, %0d mismatches",
             checked, full_inserts, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### positional_list_engine.f
sv/ple_pkg.sv
sv/ple_ram.sv
sv/positional_list_engine.sv
test/ple_result_checker.sv
test/tb_top.sv
